FILE: rtl/sorted_unique_key_insert_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef SORTED_UNIQUE_KEY_INSERT_ASSERT_SVH
`define SORTED_UNIQUE_KEY_INSERT_ASSERT_SVH

// Same-cycle implication.
`define SUKI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SUKI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sukins_pkg.sv
package sukins_pkg;

    localparam int KEY_W = 64;
    localparam int POS_W = 11;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             table_full;
        logic [POS_W-1:0] stored_count;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic set_full;
        logic shift_start;
        logic shift_step;
        logic write_key;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic srch_done;
        logic is_insert;
        logic hit;
        logic full;
        logic shift_done;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/sukins_chan_if.sv
interface sukins_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sukins_ctrl.sv
module sukins_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sukins_pkg::t_dp_sts i_sts,
    output sukins_pkg::t_dp_cmd o_cmd
);

    sukins_pkg::t_state r_state;
    sukins_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sukins_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sukins_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sukins_pkg::ST_SRCH;
                end
            end
            sukins_pkg::ST_SRCH: begin
                if (!i_sts.srch_done) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = sukins_pkg::ST_SRCH_CMP;
                end else if (i_sts.is_insert && !i_sts.hit) begin
                    if (i_sts.full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = sukins_pkg::ST_DONE;
                    end else begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = sukins_pkg::ST_SHIFT;
                    end
                end else begin
                    n_state = sukins_pkg::ST_DONE;
                end
            end
            sukins_pkg::ST_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = sukins_pkg::ST_SRCH;
            end
            sukins_pkg::ST_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_cmd.write_key = 1'b1;
                    n_state         = sukins_pkg::ST_DONE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            sukins_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sukins_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sukins_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sukins_dp.sv
module sukins_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sukins_pkg::t_in_beat i_in_data,
    input  sukins_pkg::t_dp_cmd  i_cmd,
    output sukins_pkg::t_dp_sts  o_sts,
    sukins_chan_if.source        o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    logic [sukins_pkg::KEY_W-1:0] r_mem [CAPACITY];

    logic [sukins_pkg::KEY_W-1:0] r_key;
    logic                         r_cmd;
    logic [CNT_W-1:0]             r_lo;
    logic [CNT_W-1:0]             r_hi;
    logic [AW-1:0]                r_mid;
    logic                         r_hit;
    logic                         r_full;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_sidx;
    logic                         r_wv;
    logic [AW-1:0]                r_wa;
    logic [sukins_pkg::KEY_W-1:0] r_rdata;
    logic                         r_out_vld;
    sukins_pkg::t_out_beat        r_out;

    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_sidx_m1;
    logic             w_more;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;

    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_sidx_m1 = r_sidx - CNT_W'(1);
    assign w_more    = (r_sidx > r_lo);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_mid[AW-1:0];
        if (i_cmd.srch_rd) begin
            w_rd_en = 1'b1;
        end else if (i_cmd.shift_step && w_more) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_sidx_m1[AW-1:0];
        end
    end

    // key store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_step && r_wv) begin
            r_mem[r_wa] <= r_rdata;
        end else if (i_cmd.write_key) begin
            r_mem[r_lo[AW-1:0]] <= r_key;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // search / shift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_in_data.key;
            r_cmd  <= i_in_data.command;
            r_lo   <= '0;
            r_hi   <= r_count;
            r_hit  <= 1'b0;
            r_full <= 1'b0;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= w_mid[AW-1:0];
        end
        if (i_cmd.srch_cmp) begin
            if (r_rdata < r_key) begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                r_hi  <= CNT_W'(r_mid);
                r_hit <= (r_rdata == r_key);
            end
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.shift_start) begin
            r_sidx <= r_count;
        end
        if (i_cmd.shift_step && w_more) begin
            r_sidx <= w_sidx_m1;
            r_wa   <= r_sidx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.found        <= r_hit;
            r_out.position     <= sukins_pkg::POS_W'(r_lo);
            r_out.table_full   <= r_full;
            r_out.stored_count <= sukins_pkg::POS_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.write_key) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.shift_start) begin
                r_wv <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wv <= w_more;
            end
            if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    assign o_sts.srch_done  = (r_lo == r_hi);
    assign o_sts.is_insert  = (r_cmd == sukins_pkg::CMD_INSERT);
    assign o_sts.hit        = r_hit;
    assign o_sts.full       = (r_count == CNT_W'(CAPACITY));
    assign o_sts.shift_done = !w_more && !r_wv;
    assign o_sts.out_free   = !r_out_vld || o_out.ready;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

FILE: rtl/sorted_unique_key_insert.sv
// Sorted set of distinct 64-bit unsigned keys, up to CAPACITY entries, held
// ascending in a single-port-write / single-port-read key RAM. Each input beat
// carries a command (insert or find) and a key; each produces exactly one
// output beat with found, position (index of the key, or where it belongs),
// table_full (insert of a new key dropped because the table was full) and the
// stored count after the beat. Position and count are reported modulo 2^11.
// The block works on one beat at a time. A beat is taken, then each step of the
// binary search reads the RAM and then compares, over about ceil(log2(count+1))
// steps; the block then decides and hands the result to the output register.
// An insert of a new key then moves every larger key up one slot at one entry
// per cycle through the RAM's read and write ports, and writes the new key.
// The output register lets a finished result wait for the sink while the next
// beat is taken. The RAM needs no clearing after reset; only entries below the
// count are read.
`include "sorted_unique_key_insert_assert.svh"

module sorted_unique_key_insert #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sukins_chan_if.sink   i_in,
    sukins_chan_if.source o_out
);

    sukins_pkg::t_dp_cmd w_cmd;
    sukins_pkg::t_dp_sts w_sts;
    logic                w_in_ready;

    // sequencer: search, shift, write, report
    sukins_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // key RAM, search bounds, count and output register
    sukins_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in.data),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_out     (o_out)
    );

    assign i_in.ready = w_in_ready;

    // one beat in flight: a taken beat is not followed at once by another
    `SUKI_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "input taken while previous beat still at work")

    // a dropped insert can never also be a hit
    `SUKI_ASSERT_NOW(a_full_not_found, i_clk, i_rst_n, o_out.valid,
        !(o_out.data.found && o_out.data.table_full), "found and table_full both set")

    // the new key is never written into a full table
    `SUKI_ASSERT_NOW(a_no_write_full, i_clk, i_rst_n, w_cmd.write_key,
        !w_sts.full && w_sts.is_insert && !w_sts.hit, "key write with table full or hit")

endmodule
